// ===== design/mtrr_memory_type_resolver_defines.svh =====
// assertion macros shared by the memory type resolver rtl
// no dependencies; expects clock and reset in the including module
`ifndef MTRR_MEMORY_TYPE_RESOLVER_DEFINES_SVH
`define MTRR_MEMORY_TYPE_RESOLVER_DEFINES_SVH

// same-cycle implication
`define MTRR_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("mtrr assertion failed");

// next-cycle implication
`define MTRR_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("mtrr assertion failed");

`endif

// ===== design/mtrr_pkg.sv =====
// types, constants and codes for the memory type resolver
// no dependencies
`default_nettype none

package mtrr_pkg;

   localparam int RANGE_DEPTH_DEF = 8;
   localparam int ADDR_W          = 52;
   localparam int PAGE_LSB        = 12;
   localparam int PAGE_W          = ADDR_W - PAGE_LSB;
   localparam int TYPE_W          = 8;
   localparam int IDX_W           = 3;
   localparam int CNT_W           = 4;
   localparam int VALID_BIT       = 11;
   localparam int CSR_IDX_W       = 2;

   localparam logic [TYPE_W-1:0] TYPE_UC = 8'd0;
   localparam logic [TYPE_W-1:0] TYPE_WT = 8'd4;
   localparam logic [TYPE_W-1:0] TYPE_WB = 8'd6;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_ENABLE  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DEFAULT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COUNT   = 2'd2;

   typedef struct packed {
      logic              op;
      logic [IDX_W-1:0]  range_index;
      logic [ADDR_W-1:0] base_word;
      logic [ADDR_W-1:0] mask_word;
      logic [ADDR_W-1:0] phys_addr;
   } req_type;

   typedef struct packed {
      logic [TYPE_W-1:0] mem_type;
      logic              used_default;
   } rsp_type;

   typedef struct packed {
      logic              uc;
      logic              found;
      logic [TYPE_W-1:0] res;
      logic [PAGE_W-1:0] page;
   } token_type;

   typedef struct packed {
      logic              en;
      logic [IDX_W-1:0]  index;
      logic              valid;
      logic [TYPE_W-1:0] mtype;
      logic [PAGE_W-1:0] base;
      logic [PAGE_W-1:0] mask;
   } entry_wr_type;

   typedef struct packed {
      logic             advance;
      logic [CNT_W-1:0] range_count;
   } cell_ctrl_type;

endpackage

`default_nettype wire

// ===== design/mtrr_cell.sv =====
// one range entry of the resolver chain; checks the passing token and forwards it
// depends on mtrr_pkg
`default_nettype none

module mtrr_cell
   import mtrr_pkg::*;
#(
   parameter int CELL_INDEX = 0
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire cell_ctrl_type ctrl,
   input  wire entry_wr_type  wr,
   input  wire logic          up_vld,
   input  wire token_type     up_tok,
   output logic               dn_vld,
   output token_type          dn_tok
);

   localparam logic [CNT_W:0]   CELL_POS  = (CNT_W+1)'(CELL_INDEX);
   localparam bit               WRITABLE  = CELL_INDEX < (1 << IDX_W);
   localparam logic [IDX_W-1:0] CELL_SLOT = IDX_W'(CELL_INDEX);

   logic              valid_ff;
   logic [TYPE_W-1:0] type_ff;
   logic [PAGE_W-1:0] base_ff;
   logic [PAGE_W-1:0] mask_ff;
   logic              vld_ff;
   token_type         tok_ff;
   token_type         tok_in;
   logic              wr_hit;
   logic              in_use;
   logic              hit;

   assign wr_hit = WRITABLE && wr.en && (wr.index == CELL_SLOT);
   assign in_use = {1'b0, ctrl.range_count} > CELL_POS;
   assign hit    = valid_ff && in_use && ((up_tok.page & mask_ff) == (base_ff & mask_ff));

   always_comb begin
      tok_in = up_tok;
      if (!up_tok.uc && hit) begin
         if (type_ff == TYPE_UC) begin
            tok_in.uc = 1'b1;
         end else if (!up_tok.found) begin
            tok_in.found = 1'b1;
            tok_in.res   = type_ff;
         end else if ((up_tok.res == TYPE_WB && type_ff == TYPE_WT) ||
                      (up_tok.res == TYPE_WT && type_ff == TYPE_WB)) begin
            tok_in.res = TYPE_WT;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         vld_ff   <= 1'b0;
      end else begin
         if (wr_hit) begin
            valid_ff <= wr.valid;
         end
         if (ctrl.advance) begin
            vld_ff <= up_vld;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_hit) begin
         type_ff <= wr.mtype;
         base_ff <= wr.base;
         mask_ff <= wr.mask;
      end
      if (ctrl.advance) begin
         tok_ff <= tok_in;
      end
   end

   assign dn_vld = vld_ff;
   assign dn_tok = tok_ff;

endmodule

`default_nettype wire

// ===== design/mtrr_memory_type_resolver.sv =====
// Variable-range memory type resolver. A write transfer (op 0) loads one range entry. A query
// transfer (op 1) walks a chain of RANGE_DEPTH cells, one cell per cycle while the output
// register is not stalled, each holding one range entry; the resolved type then lands in the
// output register. One item is in flight at a time: req_ready stays low from the start of a
// query until its result is loaded into the output register. Configuration writes take effect
// at once, csr_ready is always high.
// top level; depends on mtrr_pkg, mtrr_cell and mtrr_memory_type_resolver_defines.svh
`default_nettype none
`include "mtrr_memory_type_resolver_defines.svh"

module mtrr_memory_type_resolver
   import mtrr_pkg::*;
#(
   parameter int RANGE_DEPTH = RANGE_DEPTH_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire req_type              req_data,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output rsp_type                   rsp_data,
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [TYPE_W-1:0]    csr_wdata
);

   logic              enable_ff;
   logic [TYPE_W-1:0] default_ff;
   logic [CNT_W-1:0]  count_ff;
   logic              busy_ff;
   logic              busy_in;
   logic              rsp_vld_ff;
   rsp_type           rsp_data_ff;
   rsp_type           rsp_data_in;

   logic              req_accept;
   logic              query_start;
   logic              last_vld;
   logic              load;
   cell_ctrl_type     ctrl;
   entry_wr_type      wr;
   logic              tok_vld [RANGE_DEPTH+1];
   token_type         tok     [RANGE_DEPTH+1];
   logic [RANGE_DEPTH-1:0] chain_vld;

   assign req_ready   = !busy_ff;
   assign csr_ready   = 1'b1;
   assign req_accept  = req_valid && req_ready;
   assign query_start = req_accept && (req_data.op == OP_QUERY);

   assign last_vld = tok_vld[RANGE_DEPTH];
   assign load     = last_vld && (!rsp_vld_ff || rsp_ready);

   assign ctrl.advance     = !last_vld || load;
   assign ctrl.range_count = count_ff;

   assign wr.en    = req_accept && (req_data.op == OP_WRITE);
   assign wr.index = req_data.range_index;
   assign wr.valid = req_data.mask_word[VALID_BIT];
   assign wr.mtype = req_data.base_word[TYPE_W-1:0];
   assign wr.base  = req_data.base_word[ADDR_W-1:PAGE_LSB];
   assign wr.mask  = req_data.mask_word[ADDR_W-1:PAGE_LSB];

   assign tok_vld[0]   = query_start;
   assign tok[0].uc    = 1'b0;
   assign tok[0].found = 1'b0;
   assign tok[0].res   = TYPE_UC;
   assign tok[0].page  = req_data.phys_addr[ADDR_W-1:PAGE_LSB];

   for (genvar i = 0; i < RANGE_DEPTH; i++) begin : g_cell
      mtrr_cell #(
         .CELL_INDEX(i)
      ) u_cell (
         .clock  (clock),
         .reset  (reset),
         .ctrl   (ctrl),
         .wr     (wr),
         .up_vld (tok_vld[i]),
         .up_tok (tok[i]),
         .dn_vld (tok_vld[i+1]),
         .dn_tok (tok[i+1])
      );
      assign chain_vld[i] = tok_vld[i+1];
   end

   always_comb begin
      rsp_data_in.mem_type     = TYPE_UC;
      rsp_data_in.used_default = 1'b0;
      if (enable_ff && !tok[RANGE_DEPTH].uc) begin
         if (tok[RANGE_DEPTH].found) begin
            rsp_data_in.mem_type = tok[RANGE_DEPTH].res;
         end else begin
            rsp_data_in.mem_type     = default_ff;
            rsp_data_in.used_default = 1'b1;
         end
      end
   end

   always_comb begin
      busy_in = busy_ff;
      if (query_start) begin
         busy_in = 1'b1;
      end else if (load) begin
         busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff  <= 1'b0;
         default_ff <= '0;
         count_ff   <= '0;
         busy_ff    <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         if (load) begin
            rsp_vld_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_vld_ff <= 1'b0;
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_ENABLE:  enable_ff  <= csr_wdata[0];
               CSR_DEFAULT: default_ff <= csr_wdata;
               CSR_COUNT:   count_ff   <= csr_wdata[CNT_W-1:0];
               default:     ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_data_ff;

   `MTRR_ASSERT_IMPL(a_one_token, 1'b1, $onehot0(chain_vld))
   `MTRR_ASSERT_IMPL(a_idle_empty, !busy_ff, chain_vld == '0)
   `MTRR_ASSERT_NEXT(a_start_busy, query_start, busy_ff)
   `MTRR_ASSERT_NEXT(a_off_uc, load && !enable_ff, rsp_data_ff.mem_type == TYPE_UC && !rsp_data_ff.used_default)

endmodule

`default_nettype wire
